[rtl/core/lav_pkg.sv]
// Shared types, pipeline depths and rounding helpers for the look-at view matrix block.
// No dependencies; imported by every module of the block.
package lav_pkg;

  localparam int IN_W = 288;
  localparam int OUT_W = 384;

  localparam int SQ_STEPS = 31;
  localparam int SQ_PER = 2;
  localparam int SQ_STG = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int DV_STEPS = 31;
  localparam int DV_PER = 2;
  localparam int DV_STG = (DV_STEPS + DV_PER - 1) / DV_PER;
  localparam int NORM_LAT = 5 + SQ_STG + 1 + DV_STG + 1;

  typedef logic signed [63:0] c64_t;
  typedef logic signed [31:0] c32_t;
  typedef logic [2:0][31:0] v3w_t;
  typedef logic [2:0][63:0] v3d_t;

  function automatic logic signed [63:0] mul32(logic [31:0] a, logic [31:0] b);
    return $signed(a) * $signed(b);
  endfunction

  // round right by 30, half away from zero
  function automatic logic signed [34:0] rnd30(logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] sum;
    logic [34:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    sum = mag + 64'(1 << 29);
    q = sum[64-1:29+1] & 35'h7_FFFF_FFFF;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] sat32(logic signed [34:0] v);
    if (v > 35'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -35'sh0_8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] clamp1(logic signed [34:0] v);
    if (v > 35'sh0_4000_0000) return 32'h4000_0000;
    if (v < -35'sh0_4000_0000) return 32'hC000_0000;
    return v[31:0];
  endfunction

endpackage

[rtl/core/lav_norm.sv]
// Pipelined 3-vector normalizer: magnitude scaling, square sum, integer square root
// and three restoring dividers. Output is Q1.30. Depends on lav_pkg.
module lav_norm import lav_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  c64_t in_vec [3],
  output logic out_valid,
  output c32_t out_vec [3]
);

  typedef struct packed {
    logic [2:0][62:0] mag;
    logic [2:0]       neg;
  } sa_t;

  typedef struct packed {
    logic [2:0][62:0] mag;
    logic [2:0]       neg;
    logic [5:0]       pos;
    logic             zero;
  } sb_t;

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
    logic             zero;
  } sc_t;

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][59:0] sq;
  } sd_t;

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
    logic             zero;
    logic [33:0]      rem;
    logic [30:0]      root;
    logic [61:0]      n;
  } sq_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [30:0]      len;
    logic [2:0][30:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] quo;
  } dv_t;

  function automatic logic [5:0] msb_pos(logic [62:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 63; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic sq_t sq_step(sq_t s);
    sq_t        o;
    logic [33:0] rem2;
    logic [33:0] trial;
    logic        ge;
    o = s;
    rem2 = {s.rem[31:0], s.n[61:60]};
    trial = {1'b0, s.root, 2'b01};
    ge = rem2 >= trial;
    o.rem = ge ? rem2 - trial : rem2;
    o.root = {s.root[29:0], ge};
    o.n = {s.n[59:0], 2'b00};
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t s);
    dv_t         o;
    logic [31:0] rem2;
    logic        ge;
    o = s;
    for (int i = 0; i < 3; i++) begin
      rem2 = {s.rem[i], s.low[i][30]};
      ge = rem2 >= {1'b0, s.len};
      o.rem[i] = ge ? 31'(rem2 - {1'b0, s.len}) : rem2[30:0];
      o.quo[i] = {s.quo[i][29:0], ge};
      o.low[i] = {s.low[i][29:0], 1'b0};
    end
    return o;
  endfunction

  logic [NORM_LAT-1:0] vld_r;
  sa_t sa_r;
  sb_t sb_r;
  sc_t sc_r;
  sd_t sd_r;
  sq_t sq_r [SQ_STG+1];
  dv_t dv_r [DV_STG+1];
  c32_t out_r [3];

  sa_t sa_nxt;
  sb_t sb_nxt;
  sc_t sc_nxt;
  sd_t sd_nxt;
  sq_t sq0_nxt;
  dv_t dv0_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NORM_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sa_nxt.neg[i] = in_vec[i][63];
      sa_nxt.mag[i] = in_vec[i][63] ? 63'(-in_vec[i]) : in_vec[i][62:0];
    end
  end

  always_comb begin
    logic [62:0] any;
    any = sa_r.mag[0] | sa_r.mag[1] | sa_r.mag[2];
    sb_nxt.mag = sa_r.mag;
    sb_nxt.neg = sa_r.neg;
    sb_nxt.pos = msb_pos(any);
    sb_nxt.zero = (any == '0);
  end

  always_comb begin
    logic [62:0] t;
    sc_nxt.neg = sb_r.neg;
    sc_nxt.zero = sb_r.zero;
    for (int i = 0; i < 3; i++) begin
      if (sb_r.pos >= 6'd29) begin
        t = sb_r.mag[i] >> (sb_r.pos - 6'd29);
      end else begin
        t = sb_r.mag[i] << (6'd29 - sb_r.pos);
      end
      sc_nxt.m[i] = t[29:0];
    end
  end

  always_comb begin
    sd_nxt.m = sc_r.m;
    sd_nxt.neg = sc_r.neg;
    sd_nxt.zero = sc_r.zero;
    for (int i = 0; i < 3; i++) begin
      sd_nxt.sq[i] = sc_r.m[i] * sc_r.m[i];
    end
  end

  always_comb begin
    sq0_nxt.m = sd_r.m;
    sq0_nxt.neg = sd_r.neg;
    sq0_nxt.zero = sd_r.zero;
    sq0_nxt.rem = '0;
    sq0_nxt.root = '0;
    sq0_nxt.n = 62'(sd_r.sq[0]) + 62'(sd_r.sq[1]) + 62'(sd_r.sq[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      sc_r <= sc_nxt;
      sd_r <= sd_nxt;
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar k = 1; k <= SQ_STG; k++) begin : g_sq
    sq_t st_nxt;
    always_comb begin
      st_nxt = sq_r[k-1];
      for (int s = 0; s < SQ_PER; s++) begin
        if ((k - 1) * SQ_PER + s < SQ_STEPS) st_nxt = sq_step(st_nxt);
      end
    end
    always_ff @(posedge clk) begin
      if (en) sq_r[k] <= st_nxt;
    end
  end

  always_comb begin
    logic [60:0] num;
    dv0_nxt.neg = sq_r[SQ_STG].neg;
    dv0_nxt.zero = sq_r[SQ_STG].zero;
    dv0_nxt.len = sq_r[SQ_STG].root;
    for (int i = 0; i < 3; i++) begin
      num = {1'b0, sq_r[SQ_STG].m[i], 30'b0} + 61'(sq_r[SQ_STG].root[30:1]);
      dv0_nxt.rem[i] = {1'b0, num[60:31]};
      dv0_nxt.low[i] = num[30:0];
      dv0_nxt.quo[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dv_r[0] <= dv0_nxt;
  end

  for (genvar k = 1; k <= DV_STG; k++) begin : g_dv
    dv_t st_nxt;
    always_comb begin
      st_nxt = dv_r[k-1];
      for (int s = 0; s < DV_PER; s++) begin
        if ((k - 1) * DV_PER + s < DV_STEPS) st_nxt = dv_step(st_nxt);
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[k] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_r[DV_STG].zero) begin
          out_r[i] <= '0;
        end else if (dv_r[DV_STG].neg[i]) begin
          out_r[i] <= -$signed({1'b0, dv_r[DV_STG].quo[i]});
        end else begin
          out_r[i] <= $signed({1'b0, dv_r[DV_STG].quo[i]});
        end
      end
    end
  end

  assign out_valid = vld_r[NORM_LAT-1];
  assign out_vec = out_r;

endmodule

[rtl/core/lav_ofifo.sv]
// Two-word output queue that decouples the pipeline from a stalling receiver.
// Depends on lav_pkg.
module lav_ofifo import lav_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [OUT_W-1:0] push_data,
  output logic             full,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic [OUT_W-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             pop;

  assign full = (cnt_r == 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = mem_r[rp_r];
  assign pop = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/core/look_at_view_matrix.sv]
// Top level of the look-at view matrix block: input stage, cross and dot products,
// two lav_norm normalizers and the lav_ofifo output queue. Depends on lav_pkg.
//
// Usage:
//   in_*  : one word carries eye, target and up hint (nine signed Q16.16 values).
//   out_* : one word carries side, up, back (Q1.30) and three Q16.16 translations.
//   Exactly one output word per input word, in order.
// Structure: each normalizer spends 16 stages in the square root and 16 in the
//   dividers, up to two result bits per stage.
// Throughput: one word per cycle while the output queue is not full; every stage advances together.
// Reset: rst_n clears all valid bits and the output queue; in-flight words are dropped.
// Stall: a two-word output queue holds finished words; while it is full the whole
//   pipeline freezes and in_tready is low. Nothing is lost or repeated.
module look_at_view_matrix import lav_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, hint_x, hint_y, hint_z
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // side_x..z, upv_x..z, back_x..z, shift_x, shift_y, shift_z
  output logic [OUT_W-1:0] out_tdata
);

  typedef struct packed {
    v3w_t eye;
    v3w_t hint;
  } d1_t;

  typedef struct packed {
    v3w_t eye;
    v3w_t fw;
    logic [63:0] dz;
  } d2_t;

  logic en;
  logic full;

  logic v0_r, v1_r, vx1_r, vx2_r;
  logic vu1_r, vu2_r, vu3_r, vu4_r, vu5_r, vu6_r;

  v3w_t eye0_r, tgt0_r, hint0_r;
  v3w_t eye1_r, hint1_r;
  c64_t d1_r [3];

  d1_t dl1_r [NORM_LAT];
  d2_t dl2_r [NORM_LAT];

  logic n1_valid, n2_valid;
  c32_t fw_vec [3];
  c32_t sd_vec [3];

  v3d_t px1_r_a, px1_r_b;
  v3d_t pz1_r;
  v3w_t eyex1_r, fwx1_r;
  v3w_t eyex2_r, fwx2_r;
  c64_t c2_r [3];
  logic [63:0] dz2_r;

  v3d_t ps1_a_r, ps1_b_r, pe1_r;
  v3w_t eyeu1_r, sdu1_r, fwu1_r;
  logic [63:0] dzu1_r;
  v3d_t ud2_r;
  logic [63:0] dx2_r, dzu2_r;
  v3w_t eyeu2_r, sdu2_r, fwu2_r;
  v3w_t up3_r, sdu3_r, fwu3_r, eyeu3_r;
  logic [31:0] shx3_r, shz3_r;
  v3d_t pu4_r;
  v3w_t up4_r, sdu4_r, fwu4_r;
  logic [31:0] shx4_r, shz4_r;
  logic [63:0] dy5_r;
  v3w_t up5_r, sdu5_r, fwu5_r;
  logic [31:0] shx5_r, shz5_r;
  logic [OUT_W-1:0] word6_r;

  assign en = ~full;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vx1_r <= 1'b0;
      vx2_r <= 1'b0;
      vu1_r <= 1'b0;
      vu2_r <= 1'b0;
      vu3_r <= 1'b0;
      vu4_r <= 1'b0;
      vu5_r <= 1'b0;
      vu6_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      vx1_r <= n1_valid;
      vx2_r <= vx1_r;
      vu1_r <= n2_valid;
      vu2_r <= vu1_r;
      vu3_r <= vu2_r;
      vu4_r <= vu3_r;
      vu5_r <= vu4_r;
      vu6_r <= vu5_r;
    end
  end

  // input and difference stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye0_r[i] <= in_tdata[32*i +: 32];
        tgt0_r[i] <= in_tdata[96 + 32*i +: 32];
        hint0_r[i] <= in_tdata[192 + 32*i +: 32];
        d1_r[i] <= 64'($signed(tgt0_r[i])) - 64'($signed(eye0_r[i]));
      end
      eye1_r <= eye0_r;
      hint1_r <= hint0_r;
    end
  end

  lav_norm u_norm_fw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_vec    (d1_r),
    .out_valid (n1_valid),
    .out_vec   (fw_vec)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl1_r[0] <= '{eye: eye1_r, hint: hint1_r};
      for (int k = 1; k < NORM_LAT; k++) dl1_r[k] <= dl1_r[k-1];
    end
  end

  // forward x hint and eye . forward
  always_ff @(posedge clk) begin
    if (en) begin
      px1_r_a[0] <= mul32(fw_vec[1], dl1_r[NORM_LAT-1].hint[2]);
      px1_r_b[0] <= mul32(fw_vec[2], dl1_r[NORM_LAT-1].hint[1]);
      px1_r_a[1] <= mul32(fw_vec[2], dl1_r[NORM_LAT-1].hint[0]);
      px1_r_b[1] <= mul32(fw_vec[0], dl1_r[NORM_LAT-1].hint[2]);
      px1_r_a[2] <= mul32(fw_vec[0], dl1_r[NORM_LAT-1].hint[1]);
      px1_r_b[2] <= mul32(fw_vec[1], dl1_r[NORM_LAT-1].hint[0]);
      for (int i = 0; i < 3; i++) begin
        pz1_r[i] <= mul32(dl1_r[NORM_LAT-1].eye[i], fw_vec[i]);
        fwx1_r[i] <= fw_vec[i];
      end
      eyex1_r <= dl1_r[NORM_LAT-1].eye;
      for (int i = 0; i < 3; i++) c2_r[i] <= $signed(px1_r_a[i]) - $signed(px1_r_b[i]);
      dz2_r <= pz1_r[0] + pz1_r[1] + pz1_r[2];
      eyex2_r <= eyex1_r;
      fwx2_r <= fwx1_r;
    end
  end

  lav_norm u_norm_sd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vx2_r),
    .in_vec    (c2_r),
    .out_valid (n2_valid),
    .out_vec   (sd_vec)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl2_r[0] <= '{eye: eyex2_r, fw: fwx2_r, dz: dz2_r};
      for (int k = 1; k < NORM_LAT; k++) dl2_r[k] <= dl2_r[k-1];
    end
  end

  // side x forward, eye . side, then eye . up
  always_ff @(posedge clk) begin
    if (en) begin
      ps1_a_r[0] <= mul32(sd_vec[1], dl2_r[NORM_LAT-1].fw[2]);
      ps1_b_r[0] <= mul32(sd_vec[2], dl2_r[NORM_LAT-1].fw[1]);
      ps1_a_r[1] <= mul32(sd_vec[2], dl2_r[NORM_LAT-1].fw[0]);
      ps1_b_r[1] <= mul32(sd_vec[0], dl2_r[NORM_LAT-1].fw[2]);
      ps1_a_r[2] <= mul32(sd_vec[0], dl2_r[NORM_LAT-1].fw[1]);
      ps1_b_r[2] <= mul32(sd_vec[1], dl2_r[NORM_LAT-1].fw[0]);
      for (int i = 0; i < 3; i++) begin
        pe1_r[i] <= mul32(dl2_r[NORM_LAT-1].eye[i], sd_vec[i]);
        sdu1_r[i] <= sd_vec[i];
      end
      eyeu1_r <= dl2_r[NORM_LAT-1].eye;
      fwu1_r <= dl2_r[NORM_LAT-1].fw;
      dzu1_r <= dl2_r[NORM_LAT-1].dz;

      for (int i = 0; i < 3; i++) ud2_r[i] <= ps1_a_r[i] - ps1_b_r[i];
      dx2_r <= pe1_r[0] + pe1_r[1] + pe1_r[2];
      dzu2_r <= dzu1_r;
      eyeu2_r <= eyeu1_r;
      sdu2_r <= sdu1_r;
      fwu2_r <= fwu1_r;

      for (int i = 0; i < 3; i++) up3_r[i] <= clamp1(rnd30($signed(ud2_r[i])));
      shx3_r <= sat32(rnd30(-$signed(dx2_r)));
      shz3_r <= sat32(rnd30($signed(dzu2_r)));
      eyeu3_r <= eyeu2_r;
      sdu3_r <= sdu2_r;
      fwu3_r <= fwu2_r;

      for (int i = 0; i < 3; i++) pu4_r[i] <= mul32(eyeu3_r[i], up3_r[i]);
      up4_r <= up3_r;
      sdu4_r <= sdu3_r;
      fwu4_r <= fwu3_r;
      shx4_r <= shx3_r;
      shz4_r <= shz3_r;

      dy5_r <= pu4_r[0] + pu4_r[1] + pu4_r[2];
      up5_r <= up4_r;
      sdu5_r <= sdu4_r;
      fwu5_r <= fwu4_r;
      shx5_r <= shx4_r;
      shz5_r <= shz4_r;

      for (int i = 0; i < 3; i++) begin
        word6_r[32*i +: 32] <= sdu5_r[i];
        word6_r[96 + 32*i +: 32] <= up5_r[i];
        word6_r[192 + 32*i +: 32] <= 32'(-$signed(fwu5_r[i]));
      end
      word6_r[288 +: 32] <= shx5_r;
      word6_r[320 +: 32] <= sat32(rnd30(-$signed(dy5_r)));
      word6_r[352 +: 32] <= shz5_r;
    end
  end

  lav_ofifo u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (en & vu6_r),
    .push_data  (word6_r),
    .full       (full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
